### rtl/fcsa_pkg.sv
// Shared widths, field and product indices, and stage control type for the accumulator.
package fcsa_pkg;

    localparam int IN_W   = 16;
    localparam int ACC_W  = 56;
    localparam int NORM_W = 55;
    localparam int POW_W  = 33;
    localparam int IDX_W  = 21;

    localparam int NUM_RAW  = 6;
    localparam int NUM_PROD = 16;
    localparam int NUM_COH  = 4;
    localparam int NUM_SPIN = 3;

    // Positions of the six input samples.
    localparam int R_RE0 = 0;
    localparam int R_IM0 = 1;
    localparam int R_RE1 = 2;
    localparam int R_IM1 = 3;
    localparam int R_RE2 = 4;
    localparam int R_IM2 = 5;

    // Positions of the sixteen partial products.
    localparam int P_U0U0 = 0;
    localparam int P_V0V0 = 1;
    localparam int P_U1U1 = 2;
    localparam int P_V1V1 = 3;
    localparam int P_U2U2 = 4;
    localparam int P_V2V2 = 5;
    localparam int P_U1U0 = 6;
    localparam int P_V1V0 = 7;
    localparam int P_V1U0 = 8;
    localparam int P_U1V0 = 9;
    localparam int P_U2U0 = 10;
    localparam int P_V2V0 = 11;
    localparam int P_V2U0 = 12;
    localparam int P_U2V0 = 13;
    localparam int P_U1V2 = 14;
    localparam int P_V1U2 = 15;

    // Positions of the coherence and spin sums.
    localparam int C10_RE = 0;
    localparam int C10_IM = 1;
    localparam int C20_RE = 2;
    localparam int C20_IM = 3;
    localparam int S_01   = 0;
    localparam int S_12   = 1;
    localparam int S_20   = 2;

    typedef struct packed {
        logic valid;
        logic last;
    } fcsa_ctl_t;

    // Width of a sample as the datapath sees it. Samples wider than the
    // field are the field zero-extended, so one extra bit holds them.
    function automatic int samp_width(input int sample_bits);
        return (sample_bits > IN_W) ? IN_W + 1 : sample_bits;
    endfunction

endpackage

### rtl/fcsa_products.sv
// Input register, sample extraction and the registered partial products.
module fcsa_products #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  fcsa_pkg::fcsa_ctl_t ctl_in,
    input  logic [fcsa_pkg::IN_W-1:0] raw [fcsa_pkg::NUM_RAW],
    output fcsa_pkg::fcsa_ctl_t ctl_out,
    output logic signed [2*fcsa_pkg::samp_width(SAMPLE_BITS)-1:0] prod [fcsa_pkg::NUM_PROD]
);
    import fcsa_pkg::*;

    localparam int SW    = samp_width(SAMPLE_BITS);
    localparam int PW    = 2 * SW;
    localparam int LOW_B = (SAMPLE_BITS > IN_W) ? IN_W : SAMPLE_BITS;

    fcsa_ctl_t             ctl_in_reg;
    fcsa_ctl_t             ctl_prod_reg;
    logic [IN_W-1:0]       raw_reg [NUM_RAW];
    logic signed [SW-1:0]  samp [NUM_RAW];
    logic signed [PW-1:0]  prod_next [NUM_PROD];
    logic signed [PW-1:0]  prod_reg [NUM_PROD];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_in_reg   <= '0;
            ctl_prod_reg <= '0;
        end
        else if (en)
        begin
            ctl_in_reg   <= ctl_in;
            ctl_prod_reg <= ctl_in_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_reg  <= raw;
            prod_reg <= prod_next;
        end
    end

    genvar gi;
    generate
        if (SAMPLE_BITS > IN_W)
        begin : g_wide
            for (gi = 0; gi < NUM_RAW; gi++)
            begin : g_samp
                assign samp[gi] = signed'({1'b0, raw_reg[gi]});
            end
        end
        else
        begin : g_narrow
            for (gi = 0; gi < NUM_RAW; gi++)
            begin : g_samp
                assign samp[gi] = signed'(raw_reg[gi][LOW_B-1:0]);
            end
        end
    endgenerate

    always_comb
    begin
        prod_next[P_U0U0] = samp[R_RE0] * samp[R_RE0];
        prod_next[P_V0V0] = samp[R_IM0] * samp[R_IM0];
        prod_next[P_U1U1] = samp[R_RE1] * samp[R_RE1];
        prod_next[P_V1V1] = samp[R_IM1] * samp[R_IM1];
        prod_next[P_U2U2] = samp[R_RE2] * samp[R_RE2];
        prod_next[P_V2V2] = samp[R_IM2] * samp[R_IM2];
        prod_next[P_U1U0] = samp[R_RE1] * samp[R_RE0];
        prod_next[P_V1V0] = samp[R_IM1] * samp[R_IM0];
        prod_next[P_V1U0] = samp[R_IM1] * samp[R_RE0];
        prod_next[P_U1V0] = samp[R_RE1] * samp[R_IM0];
        prod_next[P_U2U0] = samp[R_RE2] * samp[R_RE0];
        prod_next[P_V2V0] = samp[R_IM2] * samp[R_IM0];
        prod_next[P_V2U0] = samp[R_IM2] * samp[R_RE0];
        prod_next[P_U2V0] = samp[R_RE2] * samp[R_IM0];
        prod_next[P_U1V2] = samp[R_RE1] * samp[R_IM2];
        prod_next[P_V1U2] = samp[R_IM1] * samp[R_RE2];
    end

    assign ctl_out = ctl_prod_reg;
    assign prod    = prod_reg;

endmodule

### rtl/fcsa_combine.sv
// Registered per-voxel terms: coherence terms, doubled spin terms and the squared magnitude.
module fcsa_combine #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  fcsa_pkg::fcsa_ctl_t ctl_in,
    input  logic signed [2*fcsa_pkg::samp_width(SAMPLE_BITS)-1:0] prod [fcsa_pkg::NUM_PROD],
    output fcsa_pkg::fcsa_ctl_t ctl_out,
    output logic signed [2*fcsa_pkg::samp_width(SAMPLE_BITS):0] coh_term [fcsa_pkg::NUM_COH],
    output logic signed [2*fcsa_pkg::samp_width(SAMPLE_BITS)+1:0] spin_term [fcsa_pkg::NUM_SPIN],
    output logic [2*fcsa_pkg::samp_width(SAMPLE_BITS):0] power
);
    import fcsa_pkg::*;

    localparam int PW = 2 * samp_width(SAMPLE_BITS);

    fcsa_ctl_t             ctl_reg;
    logic signed [PW:0]    coh_next [NUM_COH];
    logic signed [PW:0]    coh_reg [NUM_COH];
    logic signed [PW+1:0]  spin_next [NUM_SPIN];
    logic signed [PW+1:0]  spin_reg [NUM_SPIN];
    logic signed [PW:0]    d12;
    logic signed [PW:0]    d20;
    logic signed [PW+1:0]  power_sum;
    logic [PW:0]           power_reg;

    always_comb
    begin
        coh_next[C10_RE] = (PW+1)'(prod[P_U1U0]) + (PW+1)'(prod[P_V1V0]);
        coh_next[C10_IM] = (PW+1)'(prod[P_V1U0]) - (PW+1)'(prod[P_U1V0]);
        coh_next[C20_RE] = (PW+1)'(prod[P_U2U0]) + (PW+1)'(prod[P_V2V0]);
        coh_next[C20_IM] = (PW+1)'(prod[P_V2U0]) - (PW+1)'(prod[P_U2V0]);

        // The spin term of components 0 and 1 is twice the imaginary part of
        // their coherence; the other two need their own differences.
        d12 = (PW+1)'(prod[P_U1V2]) - (PW+1)'(prod[P_V1U2]);
        d20 = (PW+1)'(prod[P_U2V0]) - (PW+1)'(prod[P_V2U0]);
        spin_next[S_01] = signed'({coh_next[C10_IM], 1'b0});
        spin_next[S_12] = signed'({d12, 1'b0});
        spin_next[S_20] = signed'({d20, 1'b0});

        power_sum = (PW+2)'(prod[P_U0U0]) + (PW+2)'(prod[P_V0V0])
                  + (PW+2)'(prod[P_U1U1]) + (PW+2)'(prod[P_V1V1])
                  + (PW+2)'(prod[P_U2U2]) + (PW+2)'(prod[P_V2V2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coh_reg   <= coh_next;
            spin_reg  <= spin_next;
            power_reg <= power_sum[PW:0];
        end
    end

    assign ctl_out   = ctl_reg;
    assign coh_term  = coh_reg;
    assign spin_term = spin_reg;
    assign power     = power_reg;

endmodule

### rtl/fcsa_accum.sv
// Frame accumulators, peak tracker, voxel counter and the result register.
module fcsa_accum #(
    parameter int MAX_VOXELS  = 2097152,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  fcsa_pkg::fcsa_ctl_t ctl,
    input  logic signed [2*fcsa_pkg::samp_width(SAMPLE_BITS):0] coh_term [fcsa_pkg::NUM_COH],
    input  logic signed [2*fcsa_pkg::samp_width(SAMPLE_BITS)+1:0] spin_term [fcsa_pkg::NUM_SPIN],
    input  logic [2*fcsa_pkg::samp_width(SAMPLE_BITS):0] power,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [fcsa_pkg::IDX_W-1:0]  peak_index,
    output logic [fcsa_pkg::POW_W-1:0]  peak_power,
    output logic signed [fcsa_pkg::ACC_W-1:0] coh_out [fcsa_pkg::NUM_COH],
    output logic signed [fcsa_pkg::ACC_W-1:0] spin_out [fcsa_pkg::NUM_SPIN],
    output logic [fcsa_pkg::NORM_W-1:0] norm_total
);
    import fcsa_pkg::*;

    localparam int PWR_W = 2 * samp_width(SAMPLE_BITS) + 1;
    localparam int CNT_W = $clog2(MAX_VOXELS);

    logic signed [ACC_W-1:0] coh_reg [NUM_COH];
    logic signed [ACC_W-1:0] coh_next [NUM_COH];
    logic signed [ACC_W-1:0] coh_sum [NUM_COH];
    logic signed [ACC_W-1:0] spin_reg [NUM_SPIN];
    logic signed [ACC_W-1:0] spin_next [NUM_SPIN];
    logic signed [ACC_W-1:0] spin_sum [NUM_SPIN];
    logic [NORM_W-1:0]       norm_reg;
    logic [NORM_W-1:0]       norm_next;
    logic [NORM_W-1:0]       norm_sum;
    logic [POW_W-1:0]        best_power_reg;
    logic [POW_W-1:0]        best_power_next;
    logic [POW_W-1:0]        best_power_sel;
    logic [CNT_W-1:0]        best_idx_reg;
    logic [CNT_W-1:0]        best_idx_next;
    logic [CNT_W-1:0]        best_idx_sel;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic [CNT_W-1:0]        cnt_inc;
    logic [POW_W+PWR_W-1:0]  power_wide;
    logic [POW_W-1:0]        power_trim;
    logic [IDX_W+CNT_W-1:0]  idx_wide;
    logic                    take;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [IDX_W-1:0]        out_idx_reg;
    logic [IDX_W-1:0]        out_idx_next;
    logic [POW_W-1:0]        out_power_reg;
    logic [POW_W-1:0]        out_power_next;
    logic signed [ACC_W-1:0] out_coh_reg [NUM_COH];
    logic signed [ACC_W-1:0] out_coh_next [NUM_COH];
    logic signed [ACC_W-1:0] out_spin_reg [NUM_SPIN];
    logic signed [ACC_W-1:0] out_spin_next [NUM_SPIN];
    logic [NORM_W-1:0]       out_norm_reg;
    logic [NORM_W-1:0]       out_norm_next;

    assign take       = en && ctl.valid;
    assign power_wide = (POW_W+PWR_W)'(power);
    assign power_trim = power_wide[POW_W-1:0];

    // A later voxel takes the peak only when strictly larger.
    assign best_power_sel = (power_trim > best_power_reg) ? power_trim : best_power_reg;
    assign best_idx_sel   = (power_trim > best_power_reg) ? cnt_reg : best_idx_reg;
    assign idx_wide       = (IDX_W+CNT_W)'(best_idx_sel);
    assign cnt_inc = (cnt_reg == CNT_W'(MAX_VOXELS - 1)) ? '0 : cnt_reg + 1'b1;
    assign norm_sum = norm_reg + NORM_W'(power);

    always_comb
    begin
        for (int i = 0; i < NUM_COH; i++)
        begin
            coh_sum[i] = coh_reg[i] + ACC_W'(coh_term[i]);
        end
        for (int j = 0; j < NUM_SPIN; j++)
        begin
            spin_sum[j] = spin_reg[j] + ACC_W'(spin_term[j]);
        end
    end

    always_comb
    begin
        coh_next        = coh_reg;
        spin_next       = spin_reg;
        norm_next       = norm_reg;
        best_power_next = best_power_reg;
        best_idx_next   = best_idx_reg;
        cnt_next        = cnt_reg;
        out_idx_next    = out_idx_reg;
        out_power_next  = out_power_reg;
        out_coh_next    = out_coh_reg;
        out_spin_next   = out_spin_reg;
        out_norm_next   = out_norm_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (take)
        begin
            if (ctl.last)
            begin
                out_valid_next  = 1'b1;
                out_idx_next    = idx_wide[IDX_W-1:0];
                out_power_next  = best_power_sel;
                out_coh_next    = coh_sum;
                out_spin_next   = spin_sum;
                out_norm_next   = norm_sum;
                for (int i = 0; i < NUM_COH; i++)
                begin
                    coh_next[i] = '0;
                end
                for (int j = 0; j < NUM_SPIN; j++)
                begin
                    spin_next[j] = '0;
                end
                norm_next       = '0;
                best_power_next = '0;
                best_idx_next   = '0;
                cnt_next        = '0;
            end
            else
            begin
                coh_next        = coh_sum;
                spin_next       = spin_sum;
                norm_next       = norm_sum;
                best_power_next = best_power_sel;
                best_idx_next   = best_idx_sel;
                cnt_next        = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COH; i++)
            begin
                coh_reg[i] <= '0;
            end
            for (int j = 0; j < NUM_SPIN; j++)
            begin
                spin_reg[j] <= '0;
            end
            norm_reg       <= '0;
            best_power_reg <= '0;
            best_idx_reg   <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            coh_reg        <= coh_next;
            spin_reg       <= spin_next;
            norm_reg       <= norm_next;
            best_power_reg <= best_power_next;
            best_idx_reg   <= best_idx_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_idx_reg   <= out_idx_next;
        out_power_reg <= out_power_next;
        out_coh_reg   <= out_coh_next;
        out_spin_reg  <= out_spin_next;
        out_norm_reg  <= out_norm_next;
    end

    assign out_valid  = out_valid_reg;
    assign peak_index = out_idx_reg;
    assign peak_power = out_power_reg;
    assign coh_out    = out_coh_reg;
    assign spin_out   = out_spin_reg;
    assign norm_total = out_norm_reg;

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        take && ctl.last |=> norm_reg == '0 && cnt_reg == '0 && best_power_reg == '0)
        else $error("frame state not cleared after the last voxel");

    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        take && !ctl.last |=> best_power_reg >= $past(best_power_reg))
        else $error("peak power dropped within a frame");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(take && ctl.last))
        else $error("result appeared without a last voxel");

    a_hold_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.valid && ctl.last && out_valid_reg && !out_ready |-> !en)
        else $error("pipeline advanced over an unread result");

endmodule

### rtl/field_coherence_spin_accumulator.sv
// Top level of the field coherence and spin accumulator.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------------
//  in      | sink      | in_valid / in_ready   | re0 im0 re1 im1 re2 im2, frame_end
//  out     | source    | out_valid / out_ready | peak_index peak_power coh10_re coh10_im
//          |           |                       | coh20_re coh20_im spin_01 spin_12 spin_20
//          |           |                       | norm_total
//
// One voxel is accepted per cycle while the pipeline is not held; the four register
// stages (input, products, terms, accumulate) all advance together.
// The result of a frame is registered once its frame_end item has passed the input, products and terms stages.
// The whole pipeline holds only while a frame_end item waits at the accumulate
// stage and the result register still holds an unread result.
// Reset clears the accumulators, peak tracker, voxel counter and all valid flags.
module field_coherence_spin_accumulator #(
    parameter int MAX_VOXELS  = 2097152,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [fcsa_pkg::IN_W-1:0]  re0,
    input  logic signed [fcsa_pkg::IN_W-1:0]  im0,
    input  logic signed [fcsa_pkg::IN_W-1:0]  re1,
    input  logic signed [fcsa_pkg::IN_W-1:0]  im1,
    input  logic signed [fcsa_pkg::IN_W-1:0]  re2,
    input  logic signed [fcsa_pkg::IN_W-1:0]  im2,
    input  logic                              frame_end,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fcsa_pkg::IDX_W-1:0]        peak_index,
    output logic [fcsa_pkg::POW_W-1:0]        peak_power,
    output logic signed [fcsa_pkg::ACC_W-1:0] coh10_re,
    output logic signed [fcsa_pkg::ACC_W-1:0] coh10_im,
    output logic signed [fcsa_pkg::ACC_W-1:0] coh20_re,
    output logic signed [fcsa_pkg::ACC_W-1:0] coh20_im,
    output logic signed [fcsa_pkg::ACC_W-1:0] spin_01,
    output logic signed [fcsa_pkg::ACC_W-1:0] spin_12,
    output logic signed [fcsa_pkg::ACC_W-1:0] spin_20,
    output logic [fcsa_pkg::NORM_W-1:0]       norm_total
);
    import fcsa_pkg::*;

    localparam int PW = 2 * samp_width(SAMPLE_BITS);

    logic                    en;
    fcsa_ctl_t               ctl_in;
    fcsa_ctl_t               ctl_prod;
    fcsa_ctl_t               ctl_term;
    logic [IN_W-1:0]         raw [NUM_RAW];
    logic signed [PW-1:0]    prod [NUM_PROD];
    logic signed [PW:0]      coh_term [NUM_COH];
    logic signed [PW+1:0]    spin_term [NUM_SPIN];
    logic [PW:0]             power;
    logic signed [ACC_W-1:0] coh_out [NUM_COH];
    logic signed [ACC_W-1:0] spin_out [NUM_SPIN];

    // Stall only when a finished frame would overwrite an unread result.
    assign en       = !(ctl_term.valid && ctl_term.last && out_valid && !out_ready);
    assign in_ready = en;

    assign ctl_in.valid = in_valid;
    assign ctl_in.last  = frame_end;

    assign raw[R_RE0] = re0;
    assign raw[R_IM0] = im0;
    assign raw[R_RE1] = re1;
    assign raw[R_IM1] = im1;
    assign raw[R_RE2] = re2;
    assign raw[R_IM2] = im2;

    fcsa_products #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_products (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_in),
        .raw     (raw),
        .ctl_out (ctl_prod),
        .prod    (prod)
    );

    fcsa_combine #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (ctl_prod),
        .prod      (prod),
        .ctl_out   (ctl_term),
        .coh_term  (coh_term),
        .spin_term (spin_term),
        .power     (power)
    );

    fcsa_accum #(
        .MAX_VOXELS  (MAX_VOXELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .ctl        (ctl_term),
        .coh_term   (coh_term),
        .spin_term  (spin_term),
        .power      (power),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .peak_index (peak_index),
        .peak_power (peak_power),
        .coh_out    (coh_out),
        .spin_out   (spin_out),
        .norm_total (norm_total)
    );

    assign coh10_re = coh_out[C10_RE];
    assign coh10_im = coh_out[C10_IM];
    assign coh20_re = coh_out[C20_RE];
    assign coh20_im = coh_out[C20_IM];
    assign spin_01  = spin_out[S_01];
    assign spin_12  = spin_out[S_12];
    assign spin_20  = spin_out[S_20];

endmodule
